// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising clk outside reset
`define ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/sem_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package sem_pkg;

  localparam int PIX_W = 24;
  localparam int CFG_W = 11;
  localparam int COL_W = 11;
  localparam int ROW_W = 12;
  localparam int CNT_W = 22;
  localparam int SUM_W = 21;

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // largest sum whose rounded root still fits in 8 bits: 255*255 + 255
  localparam logic [SUM_W-1:0] SUM_SAT = 21'd65280;

  // per-channel 3x3 tap, indexed [column][row]
  typedef logic [2:0][2:0][7:0] chan_win_t;

  typedef struct packed {
    logic       load;
    logic       step;
    logic [2:0] bit_idx;
  } sem_ctl_t;

endpackage
`default_nettype wire

// ===== hdl/sem_mag.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sem_mag (
  input  wire logic             clk,
  input  wire sem_pkg::sem_ctl_t ctl,
  input  wire sem_pkg::chan_win_t tap,
  output logic [7:0]            mag
);
  import sem_pkg::*;

  logic signed [10:0] gx, gy;
  logic [9:0] ax, ay;
  logic [SUM_W-1:0] s;
  logic [7:0] r;
  logic [7:0] cand;
  logic [15:0] cand_sq;
  logic [16:0] rr;

  function automatic logic signed [10:0] sx(input logic [7:0] v);
    return $signed({3'b000, v});
  endfunction

  always_comb begin
    gx = (sx(tap[2][0]) + (sx(tap[2][1]) <<< 1) + sx(tap[2][2]))
       - (sx(tap[0][0]) + (sx(tap[0][1]) <<< 1) + sx(tap[0][2]));
    gy = (sx(tap[0][2]) + (sx(tap[1][2]) <<< 1) + sx(tap[2][2]))
       - (sx(tap[0][0]) + (sx(tap[1][0]) <<< 1) + sx(tap[2][0]));
    ax = gx[10] ? 10'(-gx) : gx[9:0];
    ay = gy[10] ? 10'(-gy) : gy[9:0];
    cand = r | (8'd1 << ctl.bit_idx);
    cand_sq = cand * cand;
    rr = 17'(r * r) + {9'd0, r};
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      s <= SUM_W'(ax * ax) + SUM_W'(ay * ay);
      r <= '0;
    end else if (ctl.step) begin
      if ({5'd0, cand_sq} <= s) r <= cand;
    end
  end

  // restoring root is floor; round up when s lies past r*r + r
  always_comb begin
    if (s > SUM_SAT) mag = 8'hff;
    else if (s > {4'd0, rr}) mag = r + 8'd1;
    else mag = r;
  end

endmodule
`default_nettype wire

// ===== hdl/sobel_edge_magnitude_rgb_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// 3x3 Sobel edge magnitude on an RGB raster stream.
// Input beat: pixel_rgb plus flush, taken when in_valid is high and in_stall low.
// Output beat: edge_rgb plus last_pixel, taken when out_valid is high and
// out_stall low. The result of a pixel leaves width+1 input beats later; after
// the frame the host sends width+1 flush beats to drain the last row.
// One item at a time: a result beat holds in_stall through a line store read,
// window update, gradient/square, 8 per-channel root steps and output load; a
// beat with no result, through the read and window update only. The output
// register lets the next beat enter while a result waits; a stalled receiver
// only blocks once the next result is ready. frame_width/frame_height must be
// written through cfg_wr only while idle; the block does not check it. Each
// write restarts the frame. Reset sets both to 1024 and restarts the frame.
// The line store needs no clearing: each frame reads only entries it wrote.
module sobel_edge_magnitude_rgb_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [sem_pkg::PIX_W-1:0] pixel_rgb,
  input  wire logic                      flush,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [sem_pkg::PIX_W-1:0]      edge_rgb,
  output logic                           last_pixel,
  input  wire logic                      cfg_wr,
  input  wire logic                      cfg_index,
  input  wire logic [sem_pkg::CFG_W-1:0] cfg_data
);
  import sem_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam logic [12:0] MAXW = 13'(MAX_WIDTH);
  localparam logic [12:0] MAXH = 13'(MAX_HEIGHT);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_READ = 6'b000010,
    S_WIN  = 6'b000100,
    S_MAG  = 6'b001000,
    S_ROOT = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t state, state_next;

  logic [CFG_W-1:0] frame_width, frame_height;
  logic [COL_W-1:0] w_eff;
  logic [ROW_W-1:0] h_eff;
  logic [COL_W-1:0] in_column, col_q;
  logic [ROW_W-1:0] in_row, row_q;
  logic [CNT_W-1:0] out_count, wh_last;
  logic [22:0]      wh_prod;
  logic [PIX_W-1:0] pix_q, rd_top, rd_mid, top, mid;
  logic [2:0][2:0][PIX_W-1:0] win, tap;
  logic             emit_q, last_q;
  logic [2:0]       bit_idx;
  logic [AW:0]      addr_old, addr_prev;
  // two banks of 2**AW entries, bank picked by the row parity bit
  logic [PIX_W-1:0] line_mem [2**(AW+1)];
  sem_ctl_t         ctl;
  logic [PIX_W-1:0] mag_rgb;
  logic             emit_now, frame_end;
  logic [COL_W:0]   col_inc;

  always_comb begin
    if (frame_width == '0) w_eff = COL_W'(1);
    else if ({2'b00, frame_width} > MAXW) w_eff = COL_W'(MAXW);
    else w_eff = frame_width;
    if (frame_height == '0) h_eff = ROW_W'(1);
    else if ({2'b00, frame_height} > MAXH) h_eff = ROW_W'(MAXH);
    else h_eff = {1'b0, frame_height};
    wh_prod = {12'd0, w_eff} * {11'd0, h_eff};
  end

  assign in_stall  = (state != S_IDLE);
  assign addr_old  = {row_q[0], AW'(col_q)};
  assign addr_prev = {~row_q[0], AW'(col_q)};
  assign emit_now  = (row_q >= ROW_W'(2)) || (row_q == ROW_W'(1) && col_q != '0);
  assign frame_end = emit_now && (out_count >= wh_last);
  assign col_inc   = {1'b0, col_q} + 12'd1;
  assign top       = (row_q >= ROW_W'(2)) ? rd_top : '0;
  assign mid       = (row_q >= ROW_W'(1)) ? rd_mid : '0;

  // line store: read both banks and overwrite the oldest row in the same cycle
  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      rd_top <= line_mem[addr_old];
      rd_mid <= line_mem[addr_prev];
      line_mem[addr_old] <= pix_q;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_READ;
      S_READ: state_next = S_WIN;
      S_WIN:  state_next = emit_now ? S_MAG : S_IDLE;
      S_MAG:  state_next = S_ROOT;
      S_ROOT: if (bit_idx == 3'd0) state_next = S_DONE;
      S_DONE: if (!out_valid || !out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      frame_width  <= CFG_W'(1024);
      frame_height <= CFG_W'(1024);
      in_column    <= '0;
      in_row       <= '0;
      out_count    <= '0;
      win          <= '0;
      out_valid    <= 1'b0;
      last_pixel   <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cfg_wr) begin
        if (cfg_index == REG_FRAME_WIDTH) frame_width <= cfg_data;
        else frame_height <= cfg_data;
        in_column <= '0;
        in_row    <= '0;
        out_count <= '0;
        win       <= '0;
      end
      if (state == S_IDLE && in_valid) begin
        col_q <= (in_column >= w_eff) ? '0 : in_column;
        row_q <= in_row;
        pix_q <= (flush || in_row >= h_eff) ? '0 : pixel_rgb;
      end
      if (state == S_READ) wh_last <= CNT_W'(wh_prod - 23'd1);
      if (state == S_WIN) begin
        for (int r = 0; r < 3; r++) begin
          tap[0][r] <= win[1][r];
          tap[1][r] <= win[2][r];
          win[0][r] <= (col_q == '0) ? '0 : win[1][r];
          win[1][r] <= (col_q == '0) ? '0 : win[2][r];
        end
        tap[2][0] <= (col_q == '0) ? '0 : top;
        tap[2][1] <= (col_q == '0) ? '0 : mid;
        tap[2][2] <= (col_q == '0) ? '0 : pix_q;
        win[2][0] <= top;
        win[2][1] <= mid;
        win[2][2] <= pix_q;
        emit_q <= emit_now;
        last_q <= frame_end;
        if (col_inc >= {1'b0, w_eff}) begin
          in_column <= '0;
          in_row    <= row_q + ROW_W'(1);
        end else begin
          in_column <= col_inc[COL_W-1:0];
          in_row    <= row_q;
        end
        if (emit_now) out_count <= out_count + CNT_W'(1);
        if (frame_end) begin
          in_column <= '0;
          in_row    <= '0;
          out_count <= '0;
          win       <= '0;
        end
      end
      if (state == S_MAG) bit_idx <= 3'd7;
      if (state == S_ROOT) bit_idx <= bit_idx - 3'd1;
      if (state == S_DONE && (!out_valid || !out_stall)) begin
        out_valid  <= 1'b1;
        edge_rgb   <= mag_rgb;
        last_pixel <= last_q;
      end
    end
  end

  always_comb begin
    ctl.load    = (state == S_MAG);
    ctl.step    = (state == S_ROOT);
    ctl.bit_idx = bit_idx;
  end

  for (genvar c = 0; c < 3; c++) begin : g_chan
    chan_win_t ctap;
    always_comb begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          ctap[i][j] = tap[i][j][8*c +: 8];
    end
    sem_mag u_mag (
      .clk (clk),
      .ctl (ctl),
      .tap (ctap),
      .mag (mag_rgb[8*c +: 8])
    );
  end

  `include "assert_macros.svh"

  `ASSERT_NEXT(a_accept_reads, state == S_IDLE && in_valid, state == S_READ, "accept without read")
  `ASSERT_NEXT(a_root_len, state == S_ROOT && bit_idx == 3'd0, state == S_DONE, "root overrun")
  `ASSERT_NEXT(a_frame_restart, state == S_WIN && frame_end && !cfg_wr, in_row == '0 && out_count == '0, "no restart")
  `ASSERT_NOW(a_done_emits, state == S_DONE, emit_q, "result state without result")

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import sem_pkg::*;

  localparam int MAXW = 1024;
  localparam int MAXH = 1024;
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    logic [PIX_W-1:0] rgb;
    logic             fl;
  } pixel_beat_t;

  typedef struct {
    logic [PIX_W-1:0] rgb;
    logic             last;
  } edge_beat_t;

  typedef logic [2:0][2:0][PIX_W-1:0] win_t;  // [row][col]

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [PIX_W-1:0] pixel_rgb = '0;
  logic flush = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [PIX_W-1:0] edge_rgb;
  logic last_pixel;
  logic cfg_wr = 1'b0;
  logic cfg_index = REG_FRAME_WIDTH;
  logic [CFG_W-1:0] cfg_data = '0;

  pixel_beat_t pixel_fifo[$];
  edge_beat_t  edge_expect[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int errors = 0;
  int beats_in = 0;
  int beats_out = 0;
  int frames_done = 0;
  int quiet_cycles = 0;

  // shadow state of the edge filter
  logic [10:0] width_reg, height_reg;
  logic [PIX_W-1:0] row_mem [2*MAXW];
  win_t win;
  int col_pos, row_pos, res_idx;

  sobel_edge_magnitude_rgb_core i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .pixel_rgb(pixel_rgb), .flush(flush),
    .out_valid(out_valid), .out_stall(out_stall), .edge_rgb(edge_rgb),
    .last_pixel(last_pixel),
    .cfg_wr(cfg_wr), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [7:0] chan_magnitude(win_t t, int sh);
    int p[3][3];
    int gx, gy;
    int unsigned s, r, c;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        p[i][j] = t[i][j][sh +: 8];
    gx = p[0][2] + 2 * p[1][2] + p[2][2] - p[0][0] - 2 * p[1][0] - p[2][0];
    gy = p[2][0] + 2 * p[2][1] + p[2][2] - p[0][0] - 2 * p[0][1] - p[0][2];
    s = gx * gx + gy * gy;
    if (s > 255 * 255 + 255) return 8'd255;
    r = 0;
    for (int b = 128; b != 0; b >>= 1) begin
      c = r | b;
      if (c * c <= s) r = c;
    end
    if (s > r * r + r) r++;
    return (r > 255) ? 8'd255 : r[7:0];
  endfunction

  function automatic logic [PIX_W-1:0] edge_magnitude(win_t t);
    return {chan_magnitude(t, 16), chan_magnitude(t, 8), chan_magnitude(t, 0)};
  endfunction

  function automatic void restart_frame();
    col_pos = 0;
    row_pos = 0;
    res_idx = 0;
    win = '0;
  endfunction

  function automatic int eff_width();
    return (width_reg == 0) ? 1 : (width_reg > MAXW) ? MAXW : int'(width_reg);
  endfunction

  function automatic int eff_height();
    return (height_reg == 0) ? 1 : (height_reg > MAXH) ? MAXH : int'(height_reg);
  endfunction

  function automatic void predict_edge(pixel_beat_t b);
    int w, h, a_old, a_prev;
    logic [PIX_W-1:0] pix, top, mid, res;
    logic emit;
    win_t t;
    edge_beat_t e;
    w = eff_width();
    h = eff_height();
    res = '0;
    if (col_pos >= w) col_pos = 0;
    pix = (b.fl || row_pos >= h) ? '0 : b.rgb;
    a_old = (row_pos % 2) * MAXW + col_pos;
    a_prev = ((row_pos + 1) % 2) * MAXW + col_pos;
    top = (row_pos >= 2) ? row_mem[a_old] : '0;
    mid = (row_pos >= 1) ? row_mem[a_prev] : '0;
    row_mem[a_old] = pix;
    emit = (row_pos >= 2) || (row_pos == 1 && col_pos >= 1);
    if (col_pos == 0) begin
      if (emit) begin
        // right edge of the previous row: shift in a zero column
        for (int i = 0; i < 3; i++) begin
          t[i][0] = win[i][1];
          t[i][1] = win[i][2];
          t[i][2] = '0;
        end
        res = edge_magnitude(t);
      end
      for (int i = 0; i < 3; i++) begin
        win[i][0] = '0;
        win[i][1] = '0;
      end
    end else begin
      for (int i = 0; i < 3; i++) begin
        win[i][0] = win[i][1];
        win[i][1] = win[i][2];
      end
    end
    win[0][2] = top;
    win[1][2] = mid;
    win[2][2] = pix;
    if (col_pos != 0 && emit) res = edge_magnitude(win);
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (!emit) return;
    e.rgb = res;
    e.last = 1'b0;
    if (res_idx >= w * h - 1) begin
      e.last = 1'b1;
      restart_frame();
    end else begin
      res_idx++;
    end
    edge_expect.push_back(e);
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pixel_fifo.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        pixel_rgb <= pixel_fifo[0].rgb;
        flush <= pixel_fifo[0].fl;
        void'(pixel_fifo.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // predictor and result check
  always @(posedge clk) begin
    edge_beat_t e;
    if (rst) begin
      width_reg = 11'd1024;
      height_reg = 11'd1024;
      restart_frame();
    end else begin
      if (cfg_wr) begin
        if (cfg_index == REG_FRAME_WIDTH) width_reg = cfg_data;
        else height_reg = cfg_data;
        restart_frame();
      end
      if (in_valid && !in_stall) begin
        pixel_beat_t b;
        b.rgb = pixel_rgb;
        b.fl = flush;
        predict_edge(b);
        beats_in++;
      end
      if (out_valid && !out_stall) begin
        beats_out++;
        if (edge_expect.size() == 0) begin
          $display("%0t: unexpected result beat edge_rgb=%h last_pixel=%b",
                   $time, edge_rgb, last_pixel);
          errors++;
        end else begin
          e = edge_expect.pop_front();
          if (edge_rgb !== e.rgb) begin
            $display("%0t: edge_rgb expected %h actual %h", $time, e.rgb, edge_rgb);
            errors++;
          end
          if (last_pixel !== e.last) begin
            $display("%0t: last_pixel expected %b actual %b", $time, e.last, last_pixel);
            errors++;
          end
          if (e.last) frames_done++;
        end
      end
    end
  end

  // watchdog on accepted beats
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: timeout, no beat accepted", $time);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_wr <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr <= 1'b0;
  endtask

  // wait for the block to drain, plus its worst per-beat latency
  task automatic wait_drained();
    while (pixel_fifo.size() != 0 || in_valid || edge_expect.size() != 0)
      @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic queue_pixel(logic [PIX_W-1:0] rgb, logic fl);
    pixel_beat_t b;
    b.rgb = rgb;
    b.fl = fl;
    pixel_fifo.push_back(b);
  endtask

  function automatic logic [PIX_W-1:0] rand_pixel(int mode);
    case (mode)
      0: return $urandom();
      1: return {3{8'($urandom_range(255) & 8'h0f)}} ^ 24'($urandom_range(7));
      2: return $urandom_range(1) ? 24'hffffff : 24'h000000;
      default: return {8'($urandom_range(40, 60)), 8'($urandom_range(255)),
                       8'($urandom_range(120, 130))};
    endcase
  endfunction

  // full frame plus trailing padding; wr/hr are the raw register values
  task automatic run_frame(logic [CFG_W-1:0] wr, logic [CFG_W-1:0] hr);
    int w, h, mode;
    write_reg(REG_FRAME_WIDTH, wr);
    write_reg(REG_FRAME_HEIGHT, hr);
    w = (wr == 0) ? 1 : (wr > MAXW) ? MAXW : int'(wr);
    h = (hr == 0) ? 1 : (hr > MAXH) ? MAXH : int'(hr);
    mode = $urandom_range(3);
    for (int i = 0; i < w * h; i++)
      queue_pixel(rand_pixel(mode), $urandom_range(19) == 0);
    // padding: mostly flush, sometimes a pixel past the last row
    for (int i = 0; i <= w; i++)
      queue_pixel($urandom(), $urandom_range(3) != 0);
    wait_drained();
  endtask

  initial begin
    int wr, hr;
    send_idle_pct = 18;
    recv_idle_pct = 74;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed 3x3 frame: extremes, a flush inside the frame, non-flush padding
    write_reg(REG_FRAME_WIDTH, 11'd3);
    write_reg(REG_FRAME_HEIGHT, 11'd3);
    queue_pixel(24'hffffff, 1'b0);
    queue_pixel(24'h000000, 1'b0);
    queue_pixel(24'hffffff, 1'b0);
    queue_pixel(24'h00ff00, 1'b0);
    queue_pixel(24'hffffff, 1'b1);
    queue_pixel(24'h0000ff, 1'b0);
    queue_pixel(24'hff0000, 1'b0);
    queue_pixel(24'h010101, 1'b0);
    queue_pixel(24'h808080, 1'b0);
    queue_pixel(24'h123456, 1'b0);
    queue_pixel(24'h000000, 1'b1);
    queue_pixel(24'hffffff, 1'b0);
    queue_pixel(24'h000000, 1'b1);
    wait_drained();
    // zero size registers act as one
    write_reg(REG_FRAME_WIDTH, 11'd0);
    write_reg(REG_FRAME_HEIGHT, 11'd0);
    queue_pixel(24'hffffff, 1'b0);
    queue_pixel(24'h000000, 1'b1);
    queue_pixel(24'hffffff, 1'b0);
    wait_drained();
    // back-to-back frames with no config write in between
    write_reg(REG_FRAME_WIDTH, 11'd2);
    write_reg(REG_FRAME_HEIGHT, 11'd2);
    repeat (2) begin
      for (int i = 0; i < 4; i++) queue_pixel($urandom(), 1'b0);
      for (int i = 0; i < 3; i++) queue_pixel('0, 1'b1);
    end
    wait_drained();

    // random frames, small sizes
    while (beats_in < 880) begin
      if (beats_in >= 600) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (beats_in >= 300) begin
        send_idle_pct = 74;
        recv_idle_pct = 18;
      end
      wr = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 9);
      hr = $urandom_range(1, 7);
      if ($urandom_range(11) == 0) begin
        // abandoned frame, then a restart by config write
        write_reg(REG_FRAME_WIDTH, 11'(wr));
        write_reg(REG_FRAME_HEIGHT, 11'(hr + 2));
        repeat ($urandom_range(1, wr * (hr + 1))) queue_pixel($urandom(), 1'b0);
        wait_drained();
      end else begin
        run_frame(11'(wr), 11'(hr));
      end
    end

    run_frame(11'd1, 11'd1);

    $display("Run covered %0d input beats, %0d result beats, %0d complete frames,",
             beats_in, beats_out, frames_done);
    $display("small frames from 1x1 up, zero-size registers, flush and padding beats.");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
